[rtl/pelt_pkg.sv]
// Shared constants, codes and types of the proximity enter/leave tracker.
package pelt_pkg;

    // Watch table geometry.
    localparam int WATCH_DEPTH = 64;
    localparam int IDX_W       = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;
    localparam int CNT_W       = $clog2(WATCH_DEPTH + 1);

    // Field widths.
    localparam int ID_W   = 64;
    localparam int POS_W  = 20;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RAD_W  = 42;
    localparam int OP_W   = 2;
    localparam int EV_W   = 2;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Z    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_SQ   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EXCLUDE_OWN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OWN_ID      = 3'd5;

    // Input event opcodes.
    localparam logic [OP_W-1:0] OP_SPAWN   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DESPAWN = 2'd2;

    // Reported event kinds.
    localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EV_W-1:0] EV_ENTERED = 2'd1;
    localparam logic [EV_W-1:0] EV_LEFT    = 2'd2;
    localparam logic [EV_W-1:0] EV_UPDATED = 2'd3;

    // Classified job kinds handed to the back end.
    localparam logic [1:0] JOB_NONE    = 2'd0;
    localparam logic [1:0] JOB_SPAWN   = 2'd1;
    localparam logic [1:0] JOB_UPDATE  = 2'd2;
    localparam logic [1:0] JOB_DESPAWN = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
        logic [RAD_W-1:0]        radius_sq;
        logic                    exclude_own;
        logic [ID_W-1:0]         own_id;
    } t_cfg;

    typedef struct packed {
        logic [1:0]      kind;
        logic            in_range;
        logic [ID_W-1:0] unit_id;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/pelt_front.sv]
// Front end: captures an event, computes its squared distance and classifies it.
module pelt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pelt_pkg::OP_W-1:0]       i_opcode,
    input  logic [pelt_pkg::ID_W-1:0]       i_unit_id,
    input  logic signed [pelt_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [pelt_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [pelt_pkg::POS_W-1:0] i_pos_z,
    input  pelt_pkg::t_cfg                  i_cfg,
    input  pelt_pkg::t_q_status             i_q_status,
    output logic                            o_busy,
    output logic                            o_push,
    output pelt_pkg::t_job                  o_job
);
    import pelt_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQR  = 2'd1;
    localparam logic [1:0] F_CMP  = 2'd2;

    logic [1:0]              r_f_st;
    logic [1:0]              n_f_st;
    logic [OP_W-1:0]         r_op;
    logic [ID_W-1:0]         r_id;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;
    logic signed [POS_W-1:0] r_pz;
    logic [SQ_W-1:0]         r_sq_x;
    logic [SQ_W-1:0]         r_sq_y;
    logic [SQ_W-1:0]         r_sq_z;
    logic [SQ_W-1:0]         n_sq_x;
    logic [SQ_W-1:0]         n_sq_y;
    logic [SQ_W-1:0]         n_sq_z;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [DIFF_W-1:0] w_dz;
    logic [DIFF_W-1:0]       w_mx;
    logic [DIFF_W-1:0]       w_my;
    logic [DIFF_W-1:0]       w_mz;
    logic [SUM_W-1:0]        w_sum;
    logic                    w_excluded;

    assign o_busy = (r_f_st != F_IDLE);

    // Magnitudes of the per-axis offsets; the most negative offset still fits unsigned.
    always_comb begin
        w_dx = {r_px[POS_W-1], r_px} - {i_cfg.center_x[POS_W-1], i_cfg.center_x};
        w_dy = {r_py[POS_W-1], r_py} - {i_cfg.center_y[POS_W-1], i_cfg.center_y};
        w_dz = {r_pz[POS_W-1], r_pz} - {i_cfg.center_z[POS_W-1], i_cfg.center_z};
        w_mx = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
        w_my = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
        w_mz = w_dz[DIFF_W-1] ? DIFF_W'(-w_dz) : DIFF_W'(w_dz);
        n_sq_x = SQ_W'(w_mx) * SQ_W'(w_mx);
        n_sq_y = SQ_W'(w_my) * SQ_W'(w_my);
        n_sq_z = SQ_W'(w_mz) * SQ_W'(w_mz);
    end

    always_comb begin
        w_sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
        w_excluded = i_cfg.exclude_own && (r_id == i_cfg.own_id);
        o_job.unit_id  = r_id;
        o_job.in_range = (w_sum <= SUM_W'(i_cfg.radius_sq));
        if (r_op == OP_DESPAWN) begin
            o_job.kind = JOB_DESPAWN;
        end else if ((r_op == OP_SPAWN) && !w_excluded) begin
            o_job.kind = JOB_SPAWN;
        end else if ((r_op == OP_UPDATE) && !w_excluded) begin
            o_job.kind = JOB_UPDATE;
        end else begin
            o_job.kind = JOB_NONE;
        end
        o_push = (r_f_st == F_CMP) && !i_q_status.full;
    end

    always_comb begin
        n_f_st = r_f_st;
        unique case (r_f_st)
            F_IDLE: begin
                if (i_start) n_f_st = F_SQR;
            end
            F_SQR: begin
                n_f_st = F_CMP;
            end
            F_CMP: begin
                if (!i_q_status.full) n_f_st = F_IDLE;
            end
            default: begin
                n_f_st = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_st <= F_IDLE;
        end else begin
            r_f_st <= n_f_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_f_st == F_IDLE) && i_start) begin
            r_op <= i_opcode;
            r_id <= i_unit_id;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
        end
        if (r_f_st == F_SQR) begin
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
            r_sq_z <= n_sq_z;
        end
    end

endmodule

[rtl/pelt_queue.sv]
// Short job queue between the front end and the table back end.
module pelt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pelt_pkg::t_job      i_job,
    input  logic                i_pop,
    output pelt_pkg::t_job      o_job,
    output pelt_pkg::t_q_status o_status
);
    import pelt_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_job  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

[rtl/pelt_back.sv]
// Back end: scans the watch table for a job's id and applies the enter/leave decision.
module pelt_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pelt_pkg::t_job              i_job,
    input  pelt_pkg::t_q_status         i_q_status,
    output logic                        o_pop,
    output logic                        o_done,
    output logic [pelt_pkg::EV_W-1:0]   o_event_kind,
    output logic [pelt_pkg::ID_W-1:0]   o_event_id,
    output logic                        o_table_full
);
    import pelt_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_ACT  = 2'd2;

    logic [ID_W-1:0]        r_mem [WATCH_DEPTH];
    logic [ID_W-1:0]        r_mem_q;
    logic [WATCH_DEPTH-1:0] r_valid;

    logic [1:0]       r_b_st;
    logic [1:0]       n_b_st;
    t_job             r_job;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pend;
    logic [IDX_W-1:0] r_cidx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    logic             r_done;
    logic [EV_W-1:0]  r_kind;
    logic [ID_W-1:0]  r_id;
    logic             r_full;
    logic             n_done;
    logic [EV_W-1:0]  n_kind;
    logic             n_full;

    logic             w_scan_more;
    logic [EV_W-1:0]  w_act_kind;
    logic             w_act_full;
    logic             w_set;
    logic             w_clr;

    assign o_done       = r_done;
    assign o_event_kind = r_kind;
    assign o_event_id   = r_id;
    assign o_table_full = r_full;

    assign o_pop       = (r_b_st == B_IDLE) && !i_q_status.empty;
    assign w_scan_more = (r_b_st == B_SCAN) && (r_cnt != CNT_W'(WATCH_DEPTH));

    // Decision taken once the scan has found the matching and the first free slot.
    always_comb begin
        w_act_kind = EV_NONE;
        w_act_full = 1'b0;
        w_set      = 1'b0;
        w_clr      = 1'b0;
        unique case (r_job.kind)
            JOB_DESPAWN: begin
                if (r_hit) begin
                    w_act_kind = EV_LEFT;
                    w_clr      = 1'b1;
                end
            end
            JOB_SPAWN, JOB_UPDATE: begin
                if (r_job.in_range) begin
                    if (r_hit) begin
                        w_act_kind = (r_job.kind == JOB_SPAWN) ? EV_ENTERED : EV_UPDATED;
                    end else if (r_free) begin
                        w_act_kind = EV_ENTERED;
                        w_set      = 1'b1;
                    end else begin
                        w_act_full = 1'b1;
                    end
                end else if ((r_job.kind == JOB_UPDATE) && r_hit) begin
                    w_act_kind = EV_LEFT;
                    w_clr      = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_b_st != B_ACT) begin
            w_set = 1'b0;
            w_clr = 1'b0;
        end
    end

    always_comb begin
        n_b_st = r_b_st;
        n_done = 1'b0;
        n_kind = EV_NONE;
        n_full = 1'b0;
        unique case (r_b_st)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_job.kind == JOB_NONE) begin
                        n_done = 1'b1;
                    end else begin
                        n_b_st = B_SCAN;
                    end
                end
            end
            B_SCAN: begin
                if (!w_scan_more && !r_pend) n_b_st = B_ACT;
            end
            B_ACT: begin
                n_done = 1'b1;
                n_kind = w_act_kind;
                n_full = w_act_full;
                n_b_st = B_IDLE;
            end
            default: begin
                n_b_st = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_st  <= B_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= '0;
        end else begin
            r_b_st <= n_b_st;
            r_done <= n_done;
            r_pend <= w_scan_more;
            if (w_set) begin
                r_valid[r_free_idx] <= 1'b1;
            end else if (w_clr) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // Scan bookkeeping and result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_cnt  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end
        if (w_scan_more) begin
            r_cidx <= r_cnt[IDX_W-1:0];
            r_cnt  <= r_cnt + 1'b1;
        end
        if ((r_b_st == B_SCAN) && r_pend) begin
            if (r_valid[r_cidx] && (r_mem_q == r_job.unit_id) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cidx;
            end
            if (!r_valid[r_cidx] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cidx;
            end
        end
        r_kind <= n_kind;
        r_full <= n_full;
        r_id   <= ((n_kind != EV_NONE) || n_full) ? r_job.unit_id : '0;
    end

    // Watch table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_set) begin
            r_mem[r_free_idx] <= r_job.unit_id;
        end
        if (w_scan_more) begin
            r_mem_q <= r_mem[r_cnt[IDX_W-1:0]];
        end
    end

endmodule

[rtl/proximity_enter_leave_tracker.sv]
// Top level of the proximity enter/leave tracker: register port, front, queue and back.
// Every accepted event gives exactly one result; ignored events (unused opcode, own unit
// excluded) give it without a table scan. The back end works on one event at a time, scanning
// the whole table through the single read port of the watch table memory; the front end takes a
// new event only after the last one has gone into the queue, which waits while the queue is full.
// Reset clears the valid bits, the queue pointers and the control registers at once; there is no clearing pass.
module proximity_enter_leave_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pelt_pkg::OP_W-1:0]         i_opcode,
    input  logic [pelt_pkg::ID_W-1:0]         i_unit_id,
    input  logic signed [pelt_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [pelt_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [pelt_pkg::POS_W-1:0] i_pos_z,
    output logic                              o_done,
    output logic [pelt_pkg::EV_W-1:0]         o_event_kind,
    output logic [pelt_pkg::ID_W-1:0]         o_event_id,
    output logic                              o_table_full,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pelt_pkg::APB_AW-1:0]       paddr,
    input  logic [pelt_pkg::APB_DW-1:0]       pwdata,
    output logic [pelt_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import pelt_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_push;
    t_job                 w_front_job;
    t_job                 w_head_job;
    t_q_status            w_q_status;
    logic                 w_pop;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[APB_AW-1:APB_AW-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_CENTER_X:    r_cfg.center_x    <= pwdata[POS_W-1:0];
                REG_CENTER_Y:    r_cfg.center_y    <= pwdata[POS_W-1:0];
                REG_CENTER_Z:    r_cfg.center_z    <= pwdata[POS_W-1:0];
                REG_RADIUS_SQ:   r_cfg.radius_sq   <= pwdata[RAD_W-1:0];
                REG_EXCLUDE_OWN: r_cfg.exclude_own <= pwdata[0];
                REG_OWN_ID:      r_cfg.own_id      <= pwdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_CENTER_X:    prdata = APB_DW'(unsigned'(r_cfg.center_x));
            REG_CENTER_Y:    prdata = APB_DW'(unsigned'(r_cfg.center_y));
            REG_CENTER_Z:    prdata = APB_DW'(unsigned'(r_cfg.center_z));
            REG_RADIUS_SQ:   prdata = APB_DW'(r_cfg.radius_sq);
            REG_EXCLUDE_OWN: prdata = APB_DW'(r_cfg.exclude_own);
            REG_OWN_ID:      prdata = APB_DW'(r_cfg.own_id);
            default:         prdata = '0;
        endcase
    end

    pelt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_opcode   (i_opcode),
        .i_unit_id  (i_unit_id),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_cfg      (r_cfg),
        .i_q_status (w_q_status),
        .o_busy     (busy),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    pelt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    pelt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_head_job),
        .i_q_status   (w_q_status),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_event_kind (o_event_kind),
        .o_event_id   (o_event_id),
        .o_table_full (o_table_full)
    );

    // A rejected insert never reports an event kind.
    a_full_no_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_table_full |-> o_event_kind == EV_NONE)
        else $error("table_full reported together with an event kind");

    // A quiet result carries a zero id.
    a_quiet_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_event_kind == EV_NONE) && !o_table_full |-> o_event_id == '0)
        else $error("quiet result carries a nonzero id");

    // An accepted event keeps the front end occupied in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("front end free right after accepting an event");

    // No result strobe follows a reset cycle.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

[bench/proximity_enter_leave_tracker_tb.sv]
// Testbench for the proximity enter/leave tracker: directed and random events checked in order.
`timescale 1ns / 1ps

module proximity_enter_leave_tracker_tb;
    import pelt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_SIZE   = 96;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = WATCH_DEPTH + 16;
    localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

    typedef struct packed {
        logic [EV_W-1:0] kind;
        logic [ID_W-1:0] id;
        logic            full;
    } t_result;

    typedef logic [ID_W-1:0] t_id_list[$];

    // Mirrors the register file and the watch table, and holds the results still owed.
    class t_scoreboard;
        logic signed [POS_W-1:0] center_x, center_y, center_z;
        logic [RAD_W-1:0]        radius_sq;
        logic                    exclude_own;
        logic [ID_W-1:0]         own_id;
        logic [ID_W-1:0]         slot_id[WATCH_DEPTH];
        bit                      slot_used[WATCH_DEPTH];
        t_result                 owed_q[$];
        int                      errors;

        function new();
            center_x = '0;
            center_y = '0;
            center_z = '0;
            radius_sq = '0;
            exclude_own = 1'b0;
            own_id = '0;
            errors = 0;
            for (int i = 0; i < WATCH_DEPTH; i++) begin
                slot_id[i] = '0;
                slot_used[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_CENTER_X:    center_x = value[POS_W-1:0];
                REG_CENTER_Y:    center_y = value[POS_W-1:0];
                REG_CENTER_Z:    center_z = value[POS_W-1:0];
                REG_RADIUS_SQ:   radius_sq = value[RAD_W-1:0];
                REG_EXCLUDE_OWN: exclude_own = value[0];
                REG_OWN_ID:      own_id = value[ID_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned axis_sq(logic signed [POS_W-1:0] p,
                                          logic signed [POS_W-1:0] c);
            longint d;
            d = longint'(p) - longint'(c);
            if (d < 0) d = -d;
            return longint'(d * d);
        endfunction

        function int slot_of(logic [ID_W-1:0] id);
            for (int i = 0; i < WATCH_DEPTH; i++)
                if (slot_used[i] && slot_id[i] == id) return i;
            return -1;
        endfunction

        function int lowest_free();
            for (int i = 0; i < WATCH_DEPTH; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        // Works out the result of one accepted event and updates the table copy.
        function void note_event(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                 logic signed [POS_W-1:0] z);
            t_result          r;
            int               slot;
            int               free_idx;
            longint unsigned  dist_sq;
            r = '0;
            if (op == OP_DESPAWN) begin
                slot = slot_of(id);
                if (slot >= 0) begin
                    slot_used[slot] = 1'b0;
                    r.kind = EV_LEFT;
                end
            end else if ((op == OP_SPAWN || op == OP_UPDATE) &&
                         !(exclude_own && id == own_id)) begin
                dist_sq = axis_sq(x, center_x) + axis_sq(y, center_y) + axis_sq(z, center_z);
                slot = slot_of(id);
                if (dist_sq <= longint'(radius_sq)) begin
                    if (slot >= 0) begin
                        r.kind = (op == OP_SPAWN) ? EV_ENTERED : EV_UPDATED;
                    end else begin
                        free_idx = lowest_free();
                        if (free_idx >= 0) begin
                            slot_id[free_idx] = id;
                            slot_used[free_idx] = 1'b1;
                            r.kind = EV_ENTERED;
                        end else begin
                            r.full = 1'b1;
                        end
                    end
                end else if (op == OP_UPDATE && slot >= 0) begin
                    slot_used[slot] = 1'b0;
                    r.kind = EV_LEFT;
                end
            end
            if (r.kind != EV_NONE || r.full) r.id = id;
            owed_q.insert(owed_q.size(), r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [EV_W-1:0] kind, logic [ID_W-1:0] id, logic full);
            t_result want;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result kind=%0d id=%h with no event pending",
                                          kind, id));
                return;
            end
            want = owed_q.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("event_kind %0d, expected %0d (id %h)",
                                          kind, want.kind, want.id));
            if (id !== want.id)
                report_mismatch($sformatf("event_id %h, expected %h", id, want.id));
            if (full !== want.full)
                report_mismatch($sformatf("table_full %0b, expected %0b (id %h)",
                                          full, want.full, want.id));
        endtask

        function int pending();
            return owed_q.size();
        endfunction

        function t_id_list watched_list();
            t_id_list q;
            for (int i = 0; i < WATCH_DEPTH; i++)
                if (slot_used[i]) q.insert(q.size(), slot_id[i]);
            return q;
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_opcode;
    logic [ID_W-1:0]         i_unit_id;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic                    o_done;
    logic [EV_W-1:0]         o_event_kind;
    logic [ID_W-1:0]         o_event_id;
    logic                    o_table_full;
    logic                    psel, penable, pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    t_scoreboard       sb = new();
    logic [ID_W-1:0]   id_pool[POOL_SIZE];
    int                cycle_count;
    bit                idling_on;

    proximity_enter_leave_tracker u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_unit_id    (i_unit_id),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .o_done       (o_done),
        .o_event_kind (o_event_kind),
        .o_event_id   (o_event_id),
        .o_table_full (o_table_full),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_event_kind, o_event_id, o_table_full);
    end

    // Called at a falling edge; returns at the falling edge after the register write.
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_config(logic signed [POS_W-1:0] cx, logic signed [POS_W-1:0] cy,
                                logic signed [POS_W-1:0] cz, logic [RAD_W-1:0] rsq,
                                logic excl, logic [ID_W-1:0] own);
        reg_write(REG_CENTER_X, APB_DW'(cx));
        reg_write(REG_CENTER_Y, APB_DW'(cy));
        reg_write(REG_CENTER_Z, APB_DW'(cz));
        reg_write(REG_RADIUS_SQ, APB_DW'(rsq));
        reg_write(REG_EXCLUDE_OWN, APB_DW'(excl));
        reg_write(REG_OWN_ID, APB_DW'(own));
    endtask

    // One transaction: holds start until the block takes the event.
    task automatic send_event(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                              logic signed [POS_W-1:0] z);
        start = 1'b1;
        i_opcode = op;
        i_unit_id = id;
        i_pos_x = x;
        i_pos_y = y;
        i_pos_z = z;
        do @(posedge i_clk); while (busy);
        sb.note_event(op, id, x, y, z);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Ignored events finish early, so after the drain the task waits on to let the back end settle.
    task automatic wait_idle();
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v < longint'(POS_MIN)) return POS_MIN;
        if (v > longint'(POS_MAX)) return POS_MAX;
        return POS_W'(v);
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    function automatic logic signed [POS_W-1:0] near_pos(logic signed [POS_W-1:0] c,
                                                         int unsigned r);
        longint off;
        off = longint'($urandom_range(0, 2 * r)) - longint'(r);
        return clamp_pos(longint'(c) + off);
    endfunction

    function automatic logic signed [POS_W-1:0] rand_center();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        return rand_pos();
    endfunction

    task automatic flush_table();
        t_id_list q;
        q = sb.watched_list();
        foreach (q[i]) send_event(OP_DESPAWN, q[i], rand_pos(), rand_pos(), rand_pos());
    endtask

    task automatic run_phase(int n_items, bit fill);
        logic signed [POS_W-1:0] cx, cy, cz, px, py, pz;
        logic [RAD_W-1:0]        rsq;
        logic [ID_W-1:0]         own, id;
        logic [OP_W-1:0]         op;
        int unsigned             r, pick, pool_lo, pool_n;
        wait_idle();
        cx = rand_center();
        cy = rand_center();
        cz = rand_center();
        pick = fill ? 1 : $urandom_range(0, 5);
        case (pick)
            0: r = 0;
            1: r = 1 << POS_W;
            2, 3: r = $urandom_range(1, 4096);
            default: r = $urandom_range(1, 1 << POS_W);
        endcase
        rsq = (pick == 1) ? RADIUS_MAX : RAD_W'(longint'(r) * longint'(r));
        pool_n = fill ? POOL_SIZE : ($urandom_range(0, 1) ? 6 : 24);
        pool_lo = $urandom_range(0, POOL_SIZE - pool_n);
        own = $urandom_range(0, 1) ? id_pool[pool_lo + $urandom_range(0, pool_n - 1)]
                                   : {$urandom, $urandom};
        write_config(cx, cy, cz, rsq, 1'($urandom_range(0, 1)), own);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (fill) op = (pick < 70) ? OP_SPAWN : (pick < 90) ? OP_UPDATE : OP_DESPAWN;
            else op = (pick < 30) ? OP_SPAWN : (pick < 75) ? OP_UPDATE :
                      (pick < 95) ? OP_DESPAWN : OP_UNUSED;
            pick = $urandom_range(0, 19);
            if (pick == 0) id = {$urandom, $urandom};
            else if (pick == 1) id = own;
            else id = id_pool[pool_lo + $urandom_range(0, pool_n - 1)];
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                px = rand_pos();
                py = rand_pos();
                pz = rand_pos();
            end else if (pick == 2) begin
                // Right on the sphere surface or one step beyond it.
                px = clamp_pos(longint'(cx) + longint'(r) + $urandom_range(0, 1));
                py = cy;
                pz = cz;
            end else begin
                px = near_pos(cx, r);
                py = near_pos(cy, r);
                pz = near_pos(cz, r);
            end
            send_event(op, id, px, py, pz);
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    initial begin
        logic [ID_W-1:0] unit_a, unit_b, unit_c, unit_d, own;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_SPAWN;
        i_unit_id = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        idling_on = 1'b1;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};
        unit_a = 64'h0000_0000_0000_00A1;
        unit_b = 64'h8000_0000_0000_00B2;
        unit_c = 64'h5555_AAAA_5555_AAAA;
        unit_d = 64'hAAAA_5555_AAAA_5555;
        own    = 64'h0123_4567_89AB_CDEF;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: the enter/leave/update paths, exclusion and range extremes.
        write_config(POS_W'(160), POS_W'(-320), POS_W'(48), RAD_W'(2560000), 1'b1, own);
        send_event(OP_SPAWN, unit_a, POS_W'(200), POS_W'(-300), POS_W'(50));
        send_event(OP_SPAWN, unit_a, POS_W'(200), POS_W'(-300), POS_W'(50));
        send_event(OP_UPDATE, unit_a, POS_W'(170), POS_W'(-310), POS_W'(40));
        send_event(OP_UPDATE, unit_a, POS_W'(5000), '0, '0);
        send_event(OP_UPDATE, unit_a, POS_W'(5000), '0, '0);
        send_event(OP_UPDATE, unit_a, POS_W'(160), POS_W'(-320), POS_W'(48));
        send_event(OP_DESPAWN, unit_a, '0, '0, '0);
        send_event(OP_DESPAWN, unit_a, '0, '0, '0);
        send_event(OP_SPAWN, unit_b, POS_W'(-9000), POS_W'(9000), '0);
        send_event(OP_UNUSED, unit_b, POS_W'(160), POS_W'(-320), POS_W'(48));
        send_event(OP_SPAWN, own, POS_W'(160), POS_W'(-320), POS_W'(48));
        send_event(OP_UPDATE, own, POS_W'(160), POS_W'(-320), POS_W'(48));
        wait_idle();
        reg_write(REG_EXCLUDE_OWN, APB_DW'(1'b0));
        send_event(OP_SPAWN, own, POS_W'(160), POS_W'(-320), POS_W'(48));
        wait_idle();
        reg_write(REG_EXCLUDE_OWN, APB_DW'(1'b1));
        send_event(OP_UPDATE, own, POS_W'(-9000), POS_W'(9000), '0);
        send_event(OP_DESPAWN, own, '0, '0, '0);
        wait_idle();
        write_config(POS_MIN, POS_MIN, POS_MIN, RADIUS_MAX, 1'b0, '1);
        send_event(OP_SPAWN, '1, POS_MAX, POS_MAX, POS_MAX);
        send_event(OP_SPAWN, '0, POS_MIN, POS_MIN, POS_MIN);
        send_event(OP_DESPAWN, '1, POS_MAX, POS_MAX, POS_MAX);
        send_event(OP_DESPAWN, '0, POS_MIN, POS_MIN, POS_MIN);
        wait_idle();
        write_config('0, '0, '0, RAD_W'(25), 1'b0, '0);
        send_event(OP_SPAWN, unit_c, POS_W'(3), POS_W'(4), '0);
        send_event(OP_SPAWN, unit_d, POS_W'(3), POS_W'(-4), POS_W'(1));
        wait_idle();
        reg_write(REG_RADIUS_SQ, APB_DW'(24));
        send_event(OP_UPDATE, unit_c, POS_W'(3), POS_W'(4), '0);
        wait_idle();
        reg_write(REG_RADIUS_SQ, '0);
        send_event(OP_SPAWN, unit_c, '0, '0, '0);
        send_event(OP_UPDATE, unit_c, '0, '0, POS_W'(-1));

        // Random phases; the second one overfills the table.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) idling_on = 1'b0;
            if (ph > 1 && (ph == 2 || $urandom_range(0, 2) == 0)) flush_table();
            run_phase(150, ph == 1);
        end

        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.pending() != 0) sb.report_mismatch("expected results left over at the end");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
